// File: rtl/huffman_tree_decoder_top_macros.svh
// assertion helpers used by the walk module
`ifndef HUFFMAN_TREE_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_DECODER_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define HTD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition in one cycle implies an outcome in the next
`define HTD_ASSERT_NEXT(lbl, cond, outcome, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (outcome)) \
      else $error(msg);

`endif

// File: rtl/htd_pkg.sv
package htd_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int NODE_AW    = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
   localparam int IDX_W      = 10;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0]       symbol;
      logic             end_mark;
      logic             leaf;
      logic [IDX_W-1:0] right;
      logic [IDX_W-1:0] left;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] node_index;
      logic [IDX_W-1:0] left_child;
      logic [IDX_W-1:0] right_child;
      logic             leaf;
      logic             end_marker;
      logic [7:0]       leaf_symbol;
      logic [7:0]       data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_stream;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic               we;
      logic [NODE_AW-1:0] waddr;
      node_type           wdata;
      logic               re;
      logic [NODE_AW-1:0] raddr;
   } htd_mem_type;

endpackage

// File: rtl/htd_ram.sv
module htd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/htd_walk.sv
`include "huffman_tree_decoder_top_macros.svh"

module htd_walk (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  htd_pkg::req_type     req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output htd_pkg::rsp_type     rsp_item,
   output htd_pkg::htd_mem_type mem_req,
   input  logic [htd_pkg::NODE_W-1:0] mem_rdata
);

   import htd_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   function automatic logic [IDX_W-1:0] pick_child(node_type n, logic b);
      pick_child = b ? n.right : n.left;
   endfunction

   logic [1:0] state_ff, state_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] byte_ff, byte_in;
   node_type   root_ff, root_in;
   node_type   cur_ff, cur_in;
   logic       at_root_ff, at_root_in;
   logic       done_ff, done_in;
   logic       oob_ff, oob_in;
   logic       pend_vld_ff, pend_vld_in;
   rsp_type    pend_ff, pend_in;
   logic       out_vld_ff, out_vld_in;
   rsp_type    out_ff, out_in;

   logic       req_acc, is_dec_req, is_load, is_dec;
   logic       load_ok;
   node_type   new_node, start_src, ent, next_src;
   logic       is_leaf, out_free, blocked, step;
   logic       push_mid, push_fin;
   logic       walk_on;
   logic [IDX_W-1:0] child;
   rsp_type    new_rsp;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign is_dec_req = req_acc && (req_item.mode == MODE_DECODE);
   assign is_load    = req_acc && (req_item.mode == MODE_LOAD);
   assign is_dec     = is_dec_req && !done_ff;

   assign new_node = '{symbol:   req_item.leaf_symbol,
                       end_mark: req_item.end_marker,
                       leaf:     req_item.leaf,
                       right:    req_item.right_child,
                       left:     req_item.left_child};
   assign load_ok  = (32'(req_item.node_index) < NODE_COUNT);

   assign start_src = at_root_ff ? root_ff : cur_ff;
   // entries past the table read as an inner node pointing at the root
   assign ent       = oob_ff ? '0 : node_type'(mem_rdata);
   assign next_src  = ent.leaf ? root_ff : ent;

   assign is_leaf  = (state_ff == ST_WALK) && ent.leaf;
   assign out_free = !out_vld_ff || !rsp_stall;
   assign blocked  = is_leaf && pend_vld_ff && !out_free;
   assign step     = (state_ff == ST_WALK) && !blocked;
   assign push_mid = step && is_leaf && pend_vld_ff;
   assign push_fin = (state_ff == ST_FLUSH) && pend_vld_ff && out_free;
   assign walk_on  = step && !(ent.leaf && ent.end_mark) && (bit_ff != 3'd0);

   assign new_rsp.symbol        = ent.end_mark ? 8'd0 : ent.symbol;
   assign new_rsp.end_of_stream = ent.end_mark;
   assign new_rsp.last          = 1'b0;

   always_comb begin
      if (is_dec) begin
         child = pick_child(start_src, req_item.data_byte[7]);
      end else begin
         child = pick_child(next_src, byte_ff[bit_ff - 3'd1]);
      end
   end

   assign oob_in = (mem_req.re) ? (32'(child) >= NODE_COUNT) : oob_ff;

   always_comb begin
      mem_req.we    = is_load && load_ok;
      mem_req.waddr = NODE_AW'(req_item.node_index);
      mem_req.wdata = new_node;
      mem_req.re    = is_dec || walk_on;
      mem_req.raddr = NODE_AW'(child);
   end

   always_comb begin
      state_in   = state_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      root_in    = root_ff;
      cur_in     = cur_ff;
      at_root_in = at_root_ff;
      done_in    = done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_load) begin
               if (req_item.node_index == '0) begin
                  root_in = new_node;
               end
               at_root_in = 1'b1;
               done_in    = 1'b0;
            end else if (is_dec) begin
               state_in = ST_WALK;
               bit_in   = 3'd7;
               byte_in  = req_item.data_byte;
            end
         end
         ST_WALK: begin
            if (step) begin
               priority if (ent.leaf && ent.end_mark) begin
                  done_in    = 1'b1;
                  at_root_in = 1'b1;
                  state_in   = ST_FLUSH;
               end else if (bit_ff == 3'd0) begin
                  cur_in     = next_src;
                  at_root_in = 1'b0;
                  state_in   = ST_FLUSH;
               end else begin
                  bit_in = bit_ff - 3'd1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the pending item waits until it is known whether another one follows
   always_comb begin
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
      if (push_mid) begin
         out_in     = pend_ff;
         out_vld_in = 1'b1;
      end else if (push_fin) begin
         out_in      = pend_ff;
         out_in.last = 1'b1;
         out_vld_in  = 1'b1;
      end
      if (step && is_leaf) begin
         pend_in     = new_rsp;
         pend_vld_in = 1'b1;
      end else if (push_fin) begin
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         at_root_ff  <= 1'b1;
         done_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         at_root_ff  <= at_root_in;
         done_ff     <= done_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      bit_ff  <= bit_in;
      byte_ff <= byte_in;
      root_ff <= root_in;
      cur_ff  <= cur_in;
      oob_ff  <= oob_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_ff;

   `HTD_ASSERT(a_eos_is_last, (rsp_valid && rsp_item.end_of_stream) |-> rsp_item.last, "end item not marked last")
   `HTD_ASSERT(a_eos_zero_sym, (rsp_valid && rsp_item.end_of_stream) |-> (rsp_item.symbol == 8'd0), "end item carries a symbol")
   `HTD_ASSERT(a_idle_no_pend, (state_ff == ST_IDLE) |-> !pend_vld_ff, "pending item left behind after a byte")
   `HTD_ASSERT_NEXT(a_done_quiet, is_dec_req && done_ff, state_ff == ST_IDLE, "walk started after end of stream")
   `HTD_ASSERT_NEXT(a_walk_len, step && (bit_ff == 3'd0), state_ff == ST_FLUSH, "walk ran past the last bit")

endmodule

// File: rtl/huffman_tree_decoder_top.sv
// Huffman decoder that walks a code tree held in a 1024-entry node memory, root at entry 0.
// A load item (mode 0) writes one node and sends the walk back to the root.
// A decode item (mode 1) is taken one bit per cycle while the result side does not stall,
// most significant bit first: each step reads the chosen child from the node memory, so a
// byte costs up to 8 dependent memory reads, plus the accept step and a step to close out
// the byte. Up to 8 result items come out per byte, the final one flagged last; an
// end-of-stream leaf gives a zero symbol with end_of_stream set, and after it decode items
// are taken and dropped until the next load. A new item is taken only while no byte is
// being walked; results wait in an output register and a pending register.
module huffman_tree_decoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  htd_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output htd_pkg::rsp_type rsp_item
);

   import htd_pkg::*;

   htd_mem_type       mem_req;
   logic [NODE_W-1:0] mem_rdata;

   htd_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   htd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_en   (mem_req.re),
      .rd_addr (mem_req.raddr),
      .rd_data (mem_rdata)
   );

endmodule

// File: dv/huffman_tree_decoder_top_test.sv
module huffman_tree_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import htd_pkg::*;

   localparam int REQ_W           = $bits(req_type);
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_CYCLES    = 30;
   localparam int ITEM_GOAL       = 320;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   // mirror of the decoder
   node_type         node_mem [NODE_COUNT];
   logic [IDX_W-1:0] walk_node;
   bit               stream_ended;
   bit               node_loaded [NODE_COUNT];
   logic [IDX_W-1:0] loaded_list [$];
   rsp_type          expected_symbols [$];

   int req_gap_max;
   int rsp_gap_max;
   bit hold_off_pending;
   int sent_items;
   int error_count;
   int idle_cycles;

   huffman_tree_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // decode items after the end of stream leave everything untouched
   function automatic void walk_code_tree(req_type item);
      node_type here;
      node_type nxt;
      rsp_type  r;
      int       n;
      n = 0;
      if (item.mode == MODE_LOAD) begin
         if (item.node_index < NODE_COUNT) begin
            node_mem[item.node_index].left     = item.left_child;
            node_mem[item.node_index].right    = item.right_child;
            node_mem[item.node_index].leaf     = item.leaf;
            node_mem[item.node_index].end_mark = item.end_marker;
            node_mem[item.node_index].symbol   = item.leaf_symbol;
            if (!node_loaded[item.node_index]) begin
               node_loaded[item.node_index] = 1'b1;
               loaded_list.push_back(item.node_index);
            end
         end
         walk_node    = '0;
         stream_ended = 1'b0;
         return;
      end
      if (stream_ended)
         return;
      for (int b = 7; b >= 0; b--) begin
         here      = node_mem[walk_node];
         walk_node = item.data_byte[b] ? here.right : here.left;
         nxt       = node_mem[walk_node];
         if (nxt.leaf) begin
            walk_node = '0;
            r.symbol        = nxt.end_mark ? 8'd0 : nxt.symbol;
            r.end_of_stream = nxt.end_mark;
            r.last          = 1'b0;
            expected_symbols.push_back(r);
            n++;
            if (nxt.end_mark) begin
               stream_ended = 1'b1;
               break;
            end
         end
      end
      if (n > 0)
         expected_symbols[expected_symbols.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (expected_symbols.size() == 0) begin
         $error("result item with nothing expected: symbol %0h end_of_stream %0b last %0b",
                got.symbol, got.end_of_stream, got.last);
         error_count++;
         return;
      end
      want = expected_symbols.pop_front();
      if (got.symbol !== want.symbol) begin
         $error("symbol: expected %0h, got %0h", want.symbol, got.symbol);
         error_count++;
      end
      if (got.end_of_stream !== want.end_of_stream) begin
         $error("end_of_stream: expected %0b, got %0b", want.end_of_stream, got.end_of_stream);
         error_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, got.last);
         error_count++;
      end
   endfunction

   function automatic node_type make_node(logic [IDX_W-1:0] l, logic [IDX_W-1:0] r,
                                          logic lf, logic em, logic [7:0] sym);
      node_type n;
      n.left     = l;
      n.right    = r;
      n.leaf     = lf;
      n.end_mark = em;
      n.symbol   = sym;
      return n;
   endfunction

   // unused fields carry random bits
   function automatic req_type load_item(logic [IDX_W-1:0] idx, node_type n);
      req_type r;
      r             = REQ_W'({$urandom, $urandom});
      r.mode        = MODE_LOAD;
      r.node_index  = idx;
      r.left_child  = n.left;
      r.right_child = n.right;
      r.leaf        = n.leaf;
      r.end_marker  = n.end_mark;
      r.leaf_symbol = n.symbol;
      return r;
   endfunction

   function automatic req_type decode_item(logic [7:0] code_byte);
      req_type r;
      r           = REQ_W'({$urandom, $urandom});
      r.mode      = MODE_DECODE;
      r.data_byte = code_byte;
      return r;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= item;
      req_valid <= 1'b1;
      // stall seen at the falling edge decides the next rising edge
      do @(negedge clock); while (req_stall);
      walk_code_tree(item);
      sent_items++;
      @(posedge clock);
   endtask

   // full binary tree rooted at entry 0, every inner child is loaded in the same pass
   task automatic load_random_tree(input int n_leaves, input bit with_end);
      logic [IDX_W-1:0] ids [$];
      node_type         nodes [$];
      int               open_pos [$];
      bit               taken [NODE_COUNT];
      logic [IDX_W-1:0] c;
      int               pick;
      int               p;
      int               j;
      bit               reversed;
      ids.push_back('0);
      taken[0] = 1'b1;
      nodes.push_back(NODE_W'($urandom));
      open_pos.push_back(0);
      while (open_pos.size() < n_leaves) begin
         pick = $urandom_range(0, open_pos.size() - 1);
         p    = open_pos[pick];
         open_pos.delete(pick);
         nodes[p].leaf = 1'b0;
         for (int k = 0; k < 2; k++) begin
            do c = IDX_W'($urandom_range(1, NODE_COUNT - 1)); while (taken[c]);
            taken[c] = 1'b1;
            if (k == 0)
               nodes[p].left = c;
            else
               nodes[p].right = c;
            ids.push_back(c);
            nodes.push_back(NODE_W'($urandom));
            open_pos.push_back(ids.size() - 1);
         end
      end
      foreach (open_pos[i]) begin
         nodes[open_pos[i]].leaf     = 1'b1;
         nodes[open_pos[i]].end_mark = 1'b0;
      end
      if (with_end)
         nodes[open_pos[$urandom_range(0, open_pos.size() - 1)]].end_mark = 1'b1;
      reversed = $urandom_range(0, 1);
      for (int i = 0; i < ids.size(); i++) begin
         j = reversed ? ids.size() - 1 - i : i;
         send_item(load_item(ids[j], nodes[j]));
      end
   endtask

   // single stray node write; inner nodes and the root only point at loaded entries
   task automatic load_noise_node();
      node_type         n;
      logic [IDX_W-1:0] idx;
      idx = IDX_W'($urandom);
      n   = NODE_W'($urandom);
      if (idx == '0 || !n.leaf) begin
         n.left  = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
         n.right = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      end
      send_item(load_item(idx, n));
   endtask

   // root is a leaf pointing at itself: every bit gives a symbol
   task automatic test_root_leaf();
      req_gap_max = 0;
      rsp_gap_max = 0;
      send_item(load_item('0, make_node('0, '0, 1'b1, 1'b0, 8'hA5)));
      send_item(decode_item(8'h00));
      send_item(decode_item(8'hFF));
   endtask

   task automatic test_fixed_tree();
      req_gap_max = 17;
      rsp_gap_max = 17;
      send_item(load_item(10'd1023, make_node(10'd1023, 10'd1023, 1'b1, 1'b0, 8'hFF)));
      // end marker on an inner node has no effect
      send_item(load_item(10'd1, make_node(10'd2, 10'd3, 1'b0, 1'b1, 8'h5A)));
      send_item(load_item(10'd2, make_node('0, '0, 1'b1, 1'b0, 8'h00)));
      send_item(load_item(10'd3, make_node(10'd682, 10'd341, 1'b1, 1'b1, 8'h7E)));
      send_item(load_item('0, make_node(10'd1023, 10'd1, 1'b0, 1'b0, 8'h00)));
      send_item(decode_item(8'h00));
      send_item(decode_item(8'h80));
      // walk is left inside the tree at the byte boundary
      send_item(decode_item(8'h55));
      // end leaf mid-byte, the rest of the byte is dropped
      send_item(decode_item(8'hC0));
      send_item(decode_item(8'h00));
      send_item(decode_item(8'h3C));
      // a load revives the stream
      send_item(load_item(10'd3, make_node(10'd3, 10'd0, 1'b1, 1'b0, 8'h42)));
      send_item(decode_item(8'hE0));
      send_item(decode_item(8'h01));
      // load while the walk sits on an inner node sends it back to the root
      send_item(load_item(10'd2, make_node('0, '0, 1'b1, 1'b0, 8'h00)));
      send_item(decode_item(8'h80));
      send_item(decode_item(8'hFF));
   endtask

   task automatic test_output_backpressure();
      req_gap_max = 0;
      rsp_gap_max = 3;
      load_random_tree(8, 1'b0);
      hold_off_pending = 1'b1;
      repeat (24) send_item(decode_item(8'($urandom)));
   endtask

   task automatic test_random_streams();
      int n_bytes;
      while (sent_items < ITEM_GOAL) begin
         case ($urandom_range(0, 4))
            0: begin
               req_gap_max = 0;
               rsp_gap_max = 0;
            end
            1: begin
               req_gap_max = 17;
               rsp_gap_max = 17;
            end
            2: begin
               req_gap_max = 0;
               rsp_gap_max = 17;
            end
            3: begin
               req_gap_max = 17;
               rsp_gap_max = 0;
            end
            default: begin
               req_gap_max = $urandom_range(0, 17);
               rsp_gap_max = $urandom_range(0, 17);
            end
         endcase
         load_random_tree($urandom_range(2, 12), $urandom_range(0, 1));
         n_bytes = $urandom_range(4, 24);
         repeat (n_bytes) begin
            if ($urandom_range(0, 11) == 0)
               load_noise_node();
            send_item(decode_item(8'($urandom)));
         end
      end
   endtask

   initial begin : result_sink
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_pending) begin
            gap = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(negedge clock); while (!rsp_valid);
         check_result(rsp_item);
         @(posedge clock);
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[huffman_tree_decoder_top] ERROR");
         $finish;
      end
   end

   initial begin
      req_valid   <= 1'b0;
      req_item    <= '0;
      rsp_stall   <= 1'b0;
      reset       <= 1'b1;
      walk_node    = '0;
      stream_ended = 1'b0;
      req_gap_max  = 0;
      rsp_gap_max  = 0;
      sent_items   = 0;
      error_count  = 0;
      idle_cycles  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_root_leaf();
      test_fixed_tree();
      test_output_backpressure();
      test_random_streams();
      req_valid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[huffman_tree_decoder_top] OK");
      else
         $display("[huffman_tree_decoder_top] ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/htd_pkg.sv
rtl/htd_ram.sv
rtl/htd_walk.sv
rtl/huffman_tree_decoder_top.sv
dv/huffman_tree_decoder_top_test.sv
